@@ src/dlm_pkg.sv @@
package dlm_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0] BOUND_INF = 32'h8000_0000;
  localparam logic [30:0] TURN_FLOOR_RESET = 31'd66;

  localparam logic [2:0] CFG_BODY_SPEED_RSV = 3'd0;
  localparam logic [2:0] CFG_BODY_TURN_RSV = 3'd1;
  localparam logic [2:0] CFG_WHEEL_SPEED_RSV = 3'd2;
  localparam logic [2:0] CFG_ACCEL_RSV = 3'd3;
  localparam logic [2:0] CFG_DECEL_RSV = 3'd4;
  localparam logic [2:0] CFG_TURN_FLOOR = 3'd5;

  typedef struct packed {
    logic [30:0] body_speed_reserve;
    logic [30:0] body_turn_reserve;
    logic [30:0] wheel_speed_reserve;
    logic [30:0] accel_reserve;
    logic [30:0] decel_reserve;
    logic [30:0] turn_rate_floor;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] left_speed_max;
    logic signed [31:0] right_speed_max;
    logic signed [31:0] left_accel_max;
    logic signed [31:0] right_accel_max;
    logic signed [31:0] left_decel_max;
    logic signed [31:0] right_decel_max;
    logic signed [31:0] path_speed_scale;
    logic signed [31:0] path_heading_rate;
    logic signed [31:0] track_width;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [30:0] speed;
    logic [30:0] accel;
    logic [30:0] decel;
  } res_t;

endpackage

@@ src/diff_drive_path_limit_mapper.sv @@
// Maps one robot's wheel limits and path geometry to a path speed bound and
// the available path acceleration and deceleration, and gathers a fleet minimum.
// Input beats arrive on in_valid/in_stall with one field per port; results leave
// on out_valid/out_stall. Reserves and the turn floor are written on the cfg
// channel, which is always ready and must only be used while the block is idle.
// Each item runs through a sequencer that drives one shared restoring divider,
// one quotient bit per cycle. Nine divisions are needed; the track width
// division always runs, and any other ratio with a non-positive numerator or
// a zero denominator skips its division. An item with invalid limits skips
// all divisions. in_stall stays high from the accepted beat until the result
// has moved into the output register, so a new beat can be taken only once
// the previous result has moved there.
// The output register holds a result while out_stall is high, and the next item
// may be accepted and worked on meanwhile. The fleet minimum and flag are updated
// as a result enters the output register and restart after a closing beat.
// Reset clears the reserves to zero, sets the turn floor to 66 and clears the
// fleet state and both channels.
module diff_drive_path_limit_mapper #(
  parameter int FRAC_BITS = dlm_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] left_speed_max,
  input  logic signed [31:0] right_speed_max,
  input  logic signed [31:0] left_accel_max,
  input  logic signed [31:0] right_accel_max,
  input  logic signed [31:0] left_decel_max,
  input  logic signed [31:0] right_decel_max,
  input  logic signed [31:0] path_speed_scale,
  input  logic signed [31:0] path_heading_rate,
  input  logic signed [31:0] track_width,
  input  logic [31:0]        sequence_tag,
  input  logic               fleet_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        tag_out,
  output logic               robot_valid,
  output logic [30:0]        speed_bound,
  output logic [30:0]        accel_available,
  output logic [30:0]        decel_available,
  output logic [30:0]        fleet_speed_bound,
  output logic               fleet_valid,
  output logic               fleet_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  dlm_pkg::cfg_t  cfg;
  dlm_pkg::item_t item;
  dlm_pkg::res_t  res;
  logic           seq_idle;
  logic           seq_done;
  logic           in_accept;
  logic           transfer;
  logic [31:0]    tag_r;
  logic           last_r;
  logic [30:0]    fleet_min;
  logic           fleet_ok;
  logic [30:0]    min_next;
  logic           ok_next;

  assign cfg_ready = 1'b1;
  assign in_stall = !seq_idle;
  assign in_accept = in_valid && !in_stall;
  assign transfer = seq_done && (!out_valid || !out_stall);

  assign item.left_speed_max = left_speed_max;
  assign item.right_speed_max = right_speed_max;
  assign item.left_accel_max = left_accel_max;
  assign item.right_accel_max = right_accel_max;
  assign item.left_decel_max = left_decel_max;
  assign item.right_decel_max = right_decel_max;
  assign item.path_speed_scale = path_speed_scale;
  assign item.path_heading_rate = path_heading_rate;
  assign item.track_width = track_width;

  dlm_seq #(
    .FRAC_BITS(FRAC_BITS)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (in_accept),
    .item  (item),
    .cfg   (cfg),
    .take  (transfer),
    .idle  (seq_idle),
    .done  (seq_done),
    .res   (res)
  );

  assign ok_next = fleet_ok && res.valid;
  assign min_next = (res.speed < fleet_min) ? res.speed : fleet_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.body_speed_reserve <= '0;
      cfg.body_turn_reserve <= '0;
      cfg.wheel_speed_reserve <= '0;
      cfg.accel_reserve <= '0;
      cfg.decel_reserve <= '0;
      cfg.turn_rate_floor <= dlm_pkg::TURN_FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dlm_pkg::CFG_BODY_SPEED_RSV:  cfg.body_speed_reserve <= cfg_data;
        dlm_pkg::CFG_BODY_TURN_RSV:   cfg.body_turn_reserve <= cfg_data;
        dlm_pkg::CFG_WHEEL_SPEED_RSV: cfg.wheel_speed_reserve <= cfg_data;
        dlm_pkg::CFG_ACCEL_RSV:       cfg.accel_reserve <= cfg_data;
        dlm_pkg::CFG_DECEL_RSV:       cfg.decel_reserve <= cfg_data;
        dlm_pkg::CFG_TURN_FLOOR:      cfg.turn_rate_floor <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tag_r <= sequence_tag;
      last_r <= fleet_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      fleet_min <= dlm_pkg::SAT_MAX;
      fleet_ok <= 1'b1;
    end else if (transfer) begin
      out_valid <= 1'b1;
      tag_out <= tag_r;
      robot_valid <= res.valid;
      speed_bound <= res.speed;
      accel_available <= res.accel;
      decel_available <= res.decel;
      fleet_done <= last_r;
      fleet_valid <= last_r && ok_next;
      fleet_speed_bound <= (last_r && ok_next) ? min_next : 31'd0;
      fleet_min <= last_r ? dlm_pkg::SAT_MAX : min_next;
      fleet_ok <= last_r ? 1'b1 : ok_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a second beat while working");

  a_fleet_valid_needs_robot: assert property (@(posedge clk) disable iff (rst)
    out_valid && fleet_valid |-> robot_valid && fleet_done)
    else $error("fleet flagged valid with an invalid closing robot");

  a_open_fleet_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fleet_done |-> !fleet_valid && (fleet_speed_bound == 31'd0))
    else $error("fleet fields set on a beat that does not close a fleet");

  a_fleet_bound_le_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && fleet_valid |-> fleet_speed_bound <= speed_bound)
    else $error("fleet bound above the closing robot's bound");

endmodule

@@ src/dlm_divider.sv @@
module dlm_divider #(
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [63:0]   quotient
);

  localparam logic [5:0] LAST_STEP = 6'd63;

  logic [DW-1:0] rem;
  logic [63:0]   dq;
  logic [5:0]    cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign trial = {rem, dq[63]};
  assign fits = trial >= {1'b0, divisor};
  assign diff = trial - {1'b0, divisor};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= '0;
        dq <= dividend;
      end else if (busy) begin
        rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
        dq <= {dq[62:0], fits};
        cnt <= cnt + 6'd1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/dlm_seq.sv @@
module dlm_seq #(
  parameter int FRAC_BITS = dlm_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  dlm_pkg::item_t item,
  input  dlm_pkg::cfg_t  cfg,
  input  logic           take,
  output logic           idle,
  output logic           done,
  output dlm_pkg::res_t  res
);

  localparam int DW = 64 - FRAC_BITS;
  localparam int TW = 32 + FRAC_BITS;
  localparam logic [63:0] NUM_CAP = 64'd1 << (63 - FRAC_BITS);
  localparam logic [63:0] RND = (64'd1 << (FRAC_BITS + 1)) - 64'd1;

  localparam logic [3:0] OP_TURN = 4'd0;
  localparam logic [3:0] OP_BODY = 4'd1;
  localparam logic [3:0] OP_SPIN = 4'd2;
  localparam logic [3:0] OP_WL = 4'd3;
  localparam logic [3:0] OP_WR = 4'd4;
  localparam logic [3:0] OP_AL = 4'd5;
  localparam logic [3:0] OP_AR = 4'd6;
  localparam logic [3:0] OP_DL = 4'd7;
  localparam logic [3:0] OP_DR = 4'd8;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_PREP = 7'b0000100,
    S_OP   = 7'b0001000,
    S_WAIT = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_HOLD = 7'b1000000
  } state_t;

  state_t             state;
  dlm_pkg::item_t     item_r;
  logic               inval;
  logic signed [63:0] prod;
  logic [DW-1:0]      lc;
  logic [DW-1:0]      rc;
  logic [30:0]        common;
  logic [32:0]        tden;
  logic [TW-1:0]      turn;
  logic [3:0]         op;
  logic [31:0]        ratio_q [0:7];

  logic signed [63:0] prod_adj;
  logic signed [63:0] half_w;
  logic signed [63:0] lsum;
  logic signed [63:0] rsum;
  logic [32:0]        rate_ext;
  logic [32:0]        rate_abs;
  logic [63:0]        num;
  logic [DW-1:0]      den;
  logic [63:0]        numc;
  logic               num_pos;
  logic [63:0]        dividend;
  logic               div_start;
  logic               div_done;
  logic [63:0]        div_q;
  logic [31:0]        q_sat;
  logic [2:0]         ridx;
  logic [31:0]        sp01;
  logic [31:0]        sp23;
  logic [31:0]        sp;
  logic [31:0]        ax;
  logic [31:0]        dx;
  logic [31:0]        acc_c;
  logic [31:0]        dec_c;
  logic               bad_in;

  assign bad_in = item.left_speed_max[31] || item.right_speed_max[31] ||
                  item.left_accel_max[31] || item.right_accel_max[31] ||
                  item.left_decel_max[31] || item.right_decel_max[31] ||
                  item.path_speed_scale[31] || (item.path_speed_scale == 32'sd0) ||
                  item.track_width[31] || (item.track_width == 32'sd0);

  assign prod_adj = prod + $signed(prod[63] ? RND : 64'd0);
  assign half_w = prod_adj >>> (FRAC_BITS + 1);
  assign lsum = 64'(item_r.path_speed_scale) - half_w;
  assign rsum = 64'(item_r.path_speed_scale) + half_w;
  assign rate_ext = {item_r.path_heading_rate[31], item_r.path_heading_rate};
  assign rate_abs = rate_ext[32] ? (33'd0 - rate_ext) : rate_ext;

  always_comb begin
    case (op)
      OP_TURN: begin
        num = {33'd0, common};
        den = DW'(item_r.track_width[30:0]);
      end
      OP_BODY: begin
        num = {33'd0, common} - {33'd0, cfg.body_speed_reserve};
        den = DW'(item_r.path_speed_scale[30:0]);
      end
      OP_SPIN: begin
        num = 64'(turn) - {33'd0, cfg.body_turn_reserve};
        den = DW'(tden);
      end
      OP_WL: begin
        num = {32'd0, item_r.left_speed_max} - {33'd0, cfg.wheel_speed_reserve};
        den = lc;
      end
      OP_WR: begin
        num = {32'd0, item_r.right_speed_max} - {33'd0, cfg.wheel_speed_reserve};
        den = rc;
      end
      OP_AL: begin
        num = {32'd0, item_r.left_accel_max};
        den = lc;
      end
      OP_AR: begin
        num = {32'd0, item_r.right_accel_max};
        den = rc;
      end
      OP_DL: begin
        num = {32'd0, item_r.left_decel_max};
        den = lc;
      end
      OP_DR: begin
        num = {32'd0, item_r.right_decel_max};
        den = rc;
      end
      default: begin
        num = '0;
        den = '0;
      end
    endcase
  end

  assign num_pos = !num[63] && (num != 64'd0);
  assign numc = (num > NUM_CAP) ? NUM_CAP : num;
  assign dividend = (op == OP_TURN) ? (num << (FRAC_BITS + 1)) : (numc << FRAC_BITS);
  assign div_start = (state == S_OP) &&
                     ((op == OP_TURN) || (num_pos && (den != '0)));
  assign ridx = 3'(op - 4'd1);
  assign q_sat = (div_q[63:31] != '0) ? {1'b0, dlm_pkg::SAT_MAX} : div_q[31:0];

  dlm_divider #(
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sp01 = (ratio_q[0] < ratio_q[1]) ? ratio_q[0] : ratio_q[1];
  assign sp23 = (ratio_q[2] < ratio_q[3]) ? ratio_q[2] : ratio_q[3];
  assign sp = (sp01 < sp23) ? sp01 : sp23;
  assign ax = (ratio_q[4] < ratio_q[5]) ? ratio_q[4] : ratio_q[5];
  assign dx = (ratio_q[6] < ratio_q[7]) ? ratio_q[6] : ratio_q[7];
  assign acc_c = (ax == dlm_pkg::BOUND_INF) ? ax :
                 (ax > {1'b0, cfg.accel_reserve}) ? ax - {1'b0, cfg.accel_reserve} : 32'd0;
  assign dec_c = (dx == dlm_pkg::BOUND_INF) ? dx :
                 (dx > {1'b0, cfg.decel_reserve}) ? dx - {1'b0, cfg.decel_reserve} : 32'd0;

  assign idle = (state == S_IDLE);
  assign done = (state == S_HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_TURN;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            item_r <= item;
            inval <= bad_in;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= $signed(item_r.track_width) * $signed(item_r.path_heading_rate);
          op <= OP_TURN;
          state <= inval ? S_FIN : S_PREP;
        end
        S_PREP: begin
          lc <= DW'(lsum[63] ? -lsum : lsum);
          rc <= DW'(rsum[63] ? -rsum : rsum);
          common <= (item_r.left_speed_max < item_r.right_speed_max) ?
                    item_r.left_speed_max[30:0] : item_r.right_speed_max[30:0];
          tden <= rate_abs + {2'b0, cfg.turn_rate_floor};
          state <= S_OP;
        end
        S_OP: begin
          if (div_start) begin
            state <= S_WAIT;
          end else begin
            ratio_q[ridx] <= num_pos ? dlm_pkg::BOUND_INF : 32'd0;
            if (op == OP_DR) begin
              state <= S_FIN;
            end else begin
              op <= op + 4'd1;
            end
          end
        end
        S_WAIT: begin
          if (div_done) begin
            if (op == OP_TURN) begin
              turn <= div_q[TW-1:0];
            end else begin
              ratio_q[ridx] <= q_sat;
            end
            if (op == OP_DR) begin
              state <= S_FIN;
            end else begin
              op <= op + 4'd1;
              state <= S_OP;
            end
          end
        end
        S_FIN: begin
          res.valid <= !inval && (sp != dlm_pkg::BOUND_INF) &&
                       (acc_c != dlm_pkg::BOUND_INF) && (dec_c != dlm_pkg::BOUND_INF);
          res.speed <= inval ? 31'd0 :
                       (sp == dlm_pkg::BOUND_INF) ? dlm_pkg::SAT_MAX : sp[30:0];
          res.accel <= inval ? 31'd0 :
                       (acc_c == dlm_pkg::BOUND_INF) ? dlm_pkg::SAT_MAX : acc_c[30:0];
          res.decel <= inval ? 31'd0 :
                       (dec_c == dlm_pkg::BOUND_INF) ? dlm_pkg::SAT_MAX : dec_c[30:0];
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] vl, vr, al, ar, dl, dr, scale, rate, sep;
    logic [31:0] tag;
    logic last;
  } robot_t;

  typedef struct {
    logic [31:0] tag;
    logic valid;
    logic [30:0] speed, accel, decel, fleet_bound;
    logic fleet_ok, done;
  } limits_t;

  localparam logic [63:0] INF = 64'h8000_0000;
  localparam logic [63:0] SATV = 64'h7FFF_FFFF;
  localparam int FB = dlm_pkg::FRAC_BITS_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic signed [31:0] left_speed_max = '0, right_speed_max = '0, left_accel_max = '0;
  logic signed [31:0] right_accel_max = '0, left_decel_max = '0, right_decel_max = '0;
  logic signed [31:0] path_speed_scale = '0, path_heading_rate = '0, track_width = '0;
  logic [31:0] sequence_tag = '0;
  logic fleet_last = 1'b0;
  logic out_valid, out_stall = 1'b0;
  logic [31:0] tag_out;
  logic robot_valid, fleet_valid, fleet_done;
  logic [30:0] speed_bound, accel_available, decel_available, fleet_speed_bound;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  diff_drive_path_limit_mapper u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [63:0] rsv_body_speed, rsv_body_turn, rsv_wheel, rsv_accel, rsv_decel, turn_floor;
  logic [63:0] fleet_min;
  logic fleet_all_ok;
  robot_t pending_robots[$];
  limits_t expected_limits[$];
  int mismatches = 0;
  int accepted = 0;
  bit stim_done = 1'b0;

  function automatic logic [63:0] bound_ratio(longint num, longint den);
    logic [63:0] n, q;
    if (num <= 0) return 0;
    if (den <= 0) return INF;
    n = num;
    if (n > (64'd1 << (63 - FB))) n = 64'd1 << (63 - FB);
    q = (n << FB) / den;
    return q > SATV ? SATV : q;
  endfunction

  function automatic logic [63:0] umin(logic [63:0] a, logic [63:0] b);
    return a < b ? a : b;
  endfunction

  function automatic logic [63:0] minus_reserve(logic [63:0] x, logic [63:0] r);
    if (x == INF) return INF;
    return x > r ? x - r : 0;
  endfunction

  function automatic logic [30:0] as_field(logic [63:0] x);
    return x == INF ? SATV[30:0] : x[30:0];
  endfunction

  function automatic limits_t map_robot(robot_t r);
    limits_t o;
    longint vl, vr, al, ar, dl, dr, sc, rt, sp, half, lc, rc, cm, turn, rabs;
    logic [63:0] spd, acc, dec;
    vl = r.vl; vr = r.vr; al = r.al; ar = r.ar; dl = r.dl; dr = r.dr;
    sc = r.scale; rt = r.rate; sp = r.sep;
    spd = 0; acc = 0; dec = 0;
    o.valid = 1'b0;
    if (vl >= 0 && vr >= 0 && al >= 0 && ar >= 0 && dl >= 0 && dr >= 0 &&
        sc > 0 && sp > 0) begin
      half = (sp * rt) / (64'sd1 <<< (FB + 1));
      lc = sc - half; if (lc < 0) lc = -lc;
      rc = sc + half; if (rc < 0) rc = -rc;
      cm = vl < vr ? vl : vr;
      turn = (cm <<< (FB + 1)) / sp;
      rabs = rt < 0 ? -rt : rt;
      spd = umin(umin(bound_ratio(cm - longint'(rsv_body_speed), sc),
                      bound_ratio(turn - longint'(rsv_body_turn),
                                  rabs + longint'(turn_floor))),
                 umin(bound_ratio(vl - longint'(rsv_wheel), lc),
                      bound_ratio(vr - longint'(rsv_wheel), rc)));
      acc = minus_reserve(umin(bound_ratio(al, lc), bound_ratio(ar, rc)), rsv_accel);
      dec = minus_reserve(umin(bound_ratio(dl, lc), bound_ratio(dr, rc)), rsv_decel);
      o.valid = spd != INF && acc != INF && dec != INF;
    end
    o.tag = r.tag;
    o.speed = as_field(spd);
    o.accel = as_field(acc);
    o.decel = as_field(dec);
    fleet_all_ok = fleet_all_ok && o.valid;
    fleet_min = umin(fleet_min, {33'd0, as_field(spd)});
    if (r.last) begin
      o.fleet_bound = fleet_all_ok ? fleet_min[30:0] : '0;
      o.fleet_ok = fleet_all_ok;
      o.done = 1'b1;
      fleet_min = SATV;
      fleet_all_ok = 1'b1;
    end else begin
      o.fleet_bound = '0;
      o.fleet_ok = 1'b0;
      o.done = 1'b0;
    end
    return o;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Acceptance of an input beat is recorded at the falling edge after it, so the
  // rising-edge flag below keeps the model update ahead of any result.
  logic in_took = 1'b0;
  always @(posedge clk) in_took <= in_valid && !in_stall && !rst;

  int in_gap = 0;
  int out_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_took) begin
        accepted <= accepted + 1;
        expected_limits.push_back(map_robot(pending_robots.pop_front()));
        in_gap = gap_len();
      end
      if (in_took || !in_valid) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_robots.size() > 0) begin
          in_valid <= 1'b1;
          left_speed_max <= pending_robots[0].vl;
          right_speed_max <= pending_robots[0].vr;
          left_accel_max <= pending_robots[0].al;
          right_accel_max <= pending_robots[0].ar;
          left_decel_max <= pending_robots[0].dl;
          right_decel_max <= pending_robots[0].dr;
          path_speed_scale <= pending_robots[0].scale;
          path_heading_rate <= pending_robots[0].rate;
          track_width <= pending_robots[0].sep;
          sequence_tag <= pending_robots[0].tag;
          fleet_last <= pending_robots[0].last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    limits_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_limits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, tag %h", tag_out);
      end else begin
        e = expected_limits.pop_front();
        if (tag_out !== e.tag || robot_valid !== e.valid || speed_bound !== e.speed ||
            accel_available !== e.accel || decel_available !== e.decel ||
            fleet_speed_bound !== e.fleet_bound || fleet_valid !== e.fleet_ok ||
            fleet_done !== e.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch exp tag %h v%b s%h a%h d%h f%h fv%b fd%b ",
                      "got tag %h v%b s%h a%h d%h f%h fv%b fd%b"},
                     e.tag, e.valid, e.speed, e.accel, e.decel, e.fleet_bound, e.fleet_ok,
                     e.done, tag_out, robot_valid, speed_bound, accel_available,
                     decel_available, fleet_speed_bound, fleet_valid, fleet_done);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      dlm_pkg::CFG_BODY_SPEED_RSV: rsv_body_speed = val;
      dlm_pkg::CFG_BODY_TURN_RSV: rsv_body_turn = val;
      dlm_pkg::CFG_WHEEL_SPEED_RSV: rsv_wheel = val;
      dlm_pkg::CFG_ACCEL_RSV: rsv_accel = val;
      dlm_pkg::CFG_DECEL_RSV: rsv_decel = val;
      dlm_pkg::CFG_TURN_FLOOR: turn_floor = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_robots.size() > 0 || in_valid || expected_limits.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return $urandom_range(0, 32'h7FFF_FFFF);
      2: return 32'h7FFF_FFFF;
      3: return 0;
      default: return $urandom_range(1, 32'h0010_0000);
    endcase
  endfunction

  function automatic robot_t rand_robot(int tagv);
    robot_t r;
    r.vl = $urandom_range(0, 32'h0008_0000);
    r.vr = $urandom_range(0, 32'h0008_0000);
    r.al = $urandom_range(0, 32'h0004_0000);
    r.ar = $urandom_range(0, 32'h0004_0000);
    r.dl = $urandom_range(0, 32'h0004_0000);
    r.dr = $urandom_range(0, 32'h0004_0000);
    r.scale = $urandom_range(1, 32'h0002_0000);
    r.rate = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    r.sep = $urandom_range(1, 32'h0002_0000);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 9))
        0: r.vl = rand_q(); 1: r.vr = rand_q(); 2: r.al = rand_q();
        3: r.ar = rand_q(); 4: r.dl = rand_q(); 5: r.dr = rand_q();
        6: r.scale = rand_q(); 7: r.rate = rand_q(); 8: r.sep = rand_q();
        default: begin
          r.vl = $urandom; r.rate = $urandom; r.sep = $urandom; r.scale = $urandom;
        end
      endcase
    end
    r.tag = $urandom;
    if (tagv % 7 == 0) r.tag = tagv[0] ? 32'hFFFF_FFFF : 32'h0;
    r.last = $urandom_range(0, 3) == 0;
    return r;
  endfunction

  function automatic robot_t mk(logic signed [31:0] v, logic signed [31:0] a,
                                logic signed [31:0] s, logic signed [31:0] h,
                                logic signed [31:0] w, logic l);
    robot_t r;
    r.vl = v; r.vr = v; r.al = a; r.ar = a; r.dl = a; r.dr = a;
    r.scale = s; r.rate = h; r.sep = w; r.tag = $urandom; r.last = l;
    return r;
  endfunction

  initial begin
    robot_t r;
    rsv_body_speed = 0; rsv_body_turn = 0; rsv_wheel = 0; rsv_accel = 0;
    rsv_decel = 0; turn_floor = dlm_pkg::TURN_FLOOR_RESET;
    fleet_min = SATV; fleet_all_ok = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pending_robots.push_back(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0,
                                32'h0001_0000, 1'b0));
    pending_robots.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 0,
                                32'h0000_0001, 1'b1));
    pending_robots.push_back(mk(32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 0,
                                32'h0001_0000, 1'b0));
    pending_robots.push_back(mk(32'h0001_0000, 32'h0001_0000, 0, 0,
                                32'h0001_0000, 1'b1));
    pending_robots.push_back(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0,
                                32'h8000_0000, 1'b1));
    pending_robots.push_back(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                32'h0002_0000, 32'h0001_0000, 1'b0));
    pending_robots.push_back(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                32'hFFFE_0000, 32'h0001_0000, 1'b0));
    pending_robots.push_back(mk(32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    pending_robots.push_back(mk(0, 0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b1));
    r = mk(32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000, 1'b0);
    r.vl = 32'h7FFF_FFFF; r.ar = 32'h0000_0001;
    pending_robots.push_back(r);
    r.rate = 32'h8000_0000; r.last = 1'b1; r.dl = 32'hFFFF_FFFF;
    pending_robots.push_back(r);
    drain();

    write_reg(dlm_pkg::CFG_TURN_FLOOR, 31'd0);
    pending_robots.push_back(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0,
                                32'h0001_0000, 1'b1));
    pending_robots.push_back(mk(32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
                                32'h0004_0000, 32'h0001_0000, 1'b1));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < 6; i++) begin
        case (ph)
          0: write_reg(i[2:0], 31'h7FFF_FFFF);
          1: write_reg(i[2:0], i == 5 ? 31'd1 : 31'd0);
          default: write_reg(i[2:0], $urandom_range(0, 32'h0000_8000));
        endcase
      end
      for (int i = 0; i < 200; i++) pending_robots.push_back(rand_robot(i));
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (mismatches == 0 && expected_limits.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end
endmodule

@@ diff_drive_path_limit_mapper.f @@
src/dlm_pkg.sv
src/dlm_divider.sv
src/dlm_seq.sv
src/diff_drive_path_limit_mapper.sv
dv/tb_top.sv
